// ----- sv/vdc_pkg.sv -----
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types and constants for the validated decode cache.
// ----------------------------------------------------------------------------
`default_nettype none

package vdc_pkg;

  // Default sizing handed to the top-level parameters
  localparam int SLOT_COUNT_DEF     = 256;
  localparam int MAX_INSN_BYTES_DEF = 15;
  localparam int INSN_WIDTH_DEF     = 64;
  localparam int COUNT_WIDTH_DEF    = 32;

  // Fibonacci hash: low 32 bits of addr * HASH_MUL, then shifted right
  localparam logic [31:0] HASH_MUL   = 32'd2654435761;
  localparam int          HASH_SHIFT = 15;

  // Code window presented with every item
  localparam int CODE_BYTES = 15;
  localparam int CODE_W     = 8 * CODE_BYTES;
  localparam int LEN_W      = 4;  // match length / bytes available

  typedef enum logic [2:0] {
    CLASS_HIT       = 3'd0,
    CLASS_COLD      = 3'd1,
    CLASS_COLLISION = 3'd2,
    CLASS_REWRITTEN = 3'd3,
    CLASS_BYPASS    = 3'd4
  } lookup_class_e;

  // Item payload carried down the pipe (decoded record travels separately)
  typedef struct packed {
    logic [31:0]       addr;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  avail;
    logic              dec_ok;
    logic [7:0]        dec_len;
  } item_t;

endpackage

`default_nettype wire

// ----- sv/validated_decode_cache.sv -----
// ----------------------------------------------------------------------------
// validated_decode_cache
// Direct-mapped cache of decoded instructions, validated against code bytes.
// ----------------------------------------------------------------------------
// Usage: the block takes one lookup per clock (busy_o never rises) and
// returns exactly one result per lookup, in order: the input register
// takes start_i, then the hashed slot index (the 32x32 multiply) is
// registered, then the slot read from the tag/data memory, and last
// the result, which then sits on the result ports for one cycle with done_o
// high. The receiver cannot stall; it must take every beat in the cycle it
// is shown. The hit/cold/collision/rewritten counters shown with a result
// are the values just after that lookup; lookup_total_o is their sum. A
// lookup that writes a slot is forwarded to the lookup right behind it, so
// back-to-back accesses to one slot behave as if done one at a time. The
// cache_enable register (reset 1) is written through cfg_*; write it only
// while no lookup is in flight. With it at 0 the decoder result is passed
// through, nothing is counted and no slot changes. Reset empties all slots
// at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module validated_decode_cache #(
  parameter int SLOT_COUNT     = vdc_pkg::SLOT_COUNT_DEF,
  parameter int MAX_INSN_BYTES = vdc_pkg::MAX_INSN_BYTES_DEF,
  parameter int INSN_WIDTH     = vdc_pkg::INSN_WIDTH_DEF,
  parameter int COUNT_WIDTH    = vdc_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,

  // command side
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [31:0]            fetch_address_i,
  input  wire logic [63:0]            code_bytes_low_i,
  input  wire logic [55:0]            code_bytes_high_i,
  input  wire logic [3:0]             bytes_available_i,
  input  wire logic                   decoder_ok_i,
  input  wire logic [7:0]             decoder_length_i,
  input  wire logic [INSN_WIDTH-1:0]  decoder_word_i,

  // configuration write
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic                   cfg_data_i,

  // result side
  output logic                        done_o,
  output logic                        result_ok_o,
  output logic                        from_cache_o,
  output logic [2:0]                  lookup_class_o,
  output logic [INSN_WIDTH-1:0]       insn_word_o,
  output logic [7:0]                  insn_length_o,
  output logic [COUNT_WIDTH-1:0]      hit_total_o,
  output logic [COUNT_WIDTH-1:0]      cold_total_o,
  output logic [COUNT_WIDTH-1:0]      collision_total_o,
  output logic [COUNT_WIDTH-1:0]      rewritten_total_o,
  output logic [COUNT_WIDTH+1:0]      lookup_total_o
);

  localparam int SlotW  = $clog2(SLOT_COUNT);
  localparam int TotalW = COUNT_WIDTH + 2;
  localparam int CodeW  = vdc_pkg::CODE_W;
  localparam int LenW   = vdc_pkg::LEN_W;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};
  localparam logic [LenW-1:0]        MaxMatch = LenW'(MAX_INSN_BYTES);

  // --------------------------------------------------------------------------
  // Handshakes: one beat per cycle, config always taken
  // --------------------------------------------------------------------------
  logic accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic                  s1_valid_q;
  vdc_pkg::item_t        s1_item_q;
  logic [INSN_WIDTH-1:0] s1_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.addr    <= fetch_address_i;
      s1_item_q.code    <= {code_bytes_high_i, code_bytes_low_i};
      s1_item_q.avail   <= bytes_available_i;
      s1_item_q.dec_ok  <= decoder_ok_i;
      s1_item_q.dec_len <= decoder_length_i;
      s1_word_q         <= decoder_word_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: hashed slot index
  // --------------------------------------------------------------------------
  logic [31:0]           hash_prod;
  logic                  s2_valid_q;
  vdc_pkg::item_t        s2_item_q;
  logic [INSN_WIDTH-1:0] s2_word_q;
  logic [SlotW-1:0]      s2_slot_q;

  assign hash_prod = s1_item_q.addr * vdc_pkg::HASH_MUL;  // wraps at 32 bits

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_item_q <= s1_item_q;
    s2_word_q <= s1_word_q;
    s2_slot_q <= hash_prod[vdc_pkg::HASH_SHIFT +: SlotW];
  end

  // --------------------------------------------------------------------------
  // Stage 3: slot read (registered), with forwarding from the update below
  // --------------------------------------------------------------------------
  logic [31:0]           mem_tag   [SLOT_COUNT];
  logic [LenW-1:0]       mem_ml    [SLOT_COUNT];
  logic [CodeW-1:0]      mem_code  [SLOT_COUNT];
  logic [INSN_WIDTH-1:0] mem_insn  [SLOT_COUNT];
  logic [7:0]            mem_len   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_valid_q;

  logic                  s3_valid_q;
  vdc_pkg::item_t        s3_item_q;
  logic [INSN_WIDTH-1:0] s3_word_q;
  logic [SlotW-1:0]      s3_slot_q;

  logic                  rd_valid_q;
  logic [31:0]           rd_tag_q;
  logic [LenW-1:0]       rd_ml_q;
  logic [CodeW-1:0]      rd_code_q;
  logic [INSN_WIDTH-1:0] rd_insn_q;
  logic [7:0]            rd_len_q;

  // update-side signals (computed in stage 3)
  logic                  slot_upd;
  logic                  slot_fill;
  logic [LenW-1:0]       fill_ml;
  logic [CodeW-1:0]      fill_code;
  logic                  fwd;

  assign fwd = slot_upd && (s3_slot_q == s2_slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_item_q <= s2_item_q;
    s3_word_q <= s2_word_q;
    s3_slot_q <= s2_slot_q;
    rd_valid_q <= fwd ? s3_item_q.dec_ok : slot_valid_q[s2_slot_q];
    if (fwd && slot_fill) begin
      rd_tag_q  <= s3_item_q.addr;
      rd_ml_q   <= fill_ml;
      rd_code_q <= fill_code;
      rd_insn_q <= s3_word_q;
      rd_len_q  <= s3_item_q.dec_len;
    end else begin
      rd_tag_q  <= mem_tag[s2_slot_q];
      rd_ml_q   <= mem_ml[s2_slot_q];
      rd_code_q <= mem_code[s2_slot_q];
      rd_insn_q <= mem_insn[s2_slot_q];
      rd_len_q  <= mem_len[s2_slot_q];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 logic: classify, count, update slot
  // --------------------------------------------------------------------------
  logic                    code_mismatch;
  vdc_pkg::lookup_class_e  cls;
  logic                    is_hit;

  // only the first rd_ml_q bytes take part in the compare
  always_comb begin
    code_mismatch = 1'b0;
    for (int i = 0; i < vdc_pkg::CODE_BYTES; i++) begin
      if ((LenW'(i) < rd_ml_q) &&
          (rd_code_q[8*i +: 8] != s3_item_q.code[8*i +: 8])) begin
        code_mismatch = 1'b1;
      end
    end
  end

  always_comb begin
    if (!enable_q) begin
      cls = vdc_pkg::CLASS_BYPASS;
    end else if (!rd_valid_q) begin
      cls = vdc_pkg::CLASS_COLD;
    end else if (rd_tag_q != s3_item_q.addr) begin
      cls = vdc_pkg::CLASS_COLLISION;
    end else if ((rd_ml_q > s3_item_q.avail) || code_mismatch) begin
      cls = vdc_pkg::CLASS_REWRITTEN;
    end else begin
      cls = vdc_pkg::CLASS_HIT;
    end
  end

  assign is_hit    = (cls == vdc_pkg::CLASS_HIT);
  assign slot_upd  = s3_valid_q && enable_q && !is_hit;
  assign slot_fill = slot_upd && s3_item_q.dec_ok;

  // match length clamps; instruction length is kept whole
  assign fill_ml = (s3_item_q.dec_len <= 8'(MAX_INSN_BYTES)) ?
                   s3_item_q.dec_len[LenW-1:0] : MaxMatch;

  always_comb begin
    for (int i = 0; i < vdc_pkg::CODE_BYTES; i++) begin
      fill_code[8*i +: 8] = (LenW'(i) < fill_ml) ? s3_item_q.code[8*i +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (slot_upd) begin
      slot_valid_q[s3_slot_q] <= s3_item_q.dec_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_fill) begin
      mem_tag[s3_slot_q]  <= s3_item_q.addr;
      mem_ml[s3_slot_q]   <= fill_ml;
      mem_code[s3_slot_q] <= fill_code;
      mem_insn[s3_slot_q] <= s3_word_q;
      mem_len[s3_slot_q]  <= s3_item_q.dec_len;
    end
  end

  // --------------------------------------------------------------------------
  // Saturating counters; the total tracks their sum one step at a time
  // --------------------------------------------------------------------------
  logic [COUNT_WIDTH-1:0] hit_cnt_q, hit_cnt_d;
  logic [COUNT_WIDTH-1:0] cold_cnt_q, cold_cnt_d;
  logic [COUNT_WIDTH-1:0] coll_cnt_q, coll_cnt_d;
  logic [COUNT_WIDTH-1:0] rewr_cnt_q, rewr_cnt_d;
  logic [TotalW-1:0]      total_q, total_d;

  always_comb begin
    hit_cnt_d  = hit_cnt_q;
    cold_cnt_d = cold_cnt_q;
    coll_cnt_d = coll_cnt_q;
    rewr_cnt_d = rewr_cnt_q;
    total_d    = total_q;
    if (s3_valid_q) begin
      case (cls)
        vdc_pkg::CLASS_HIT: begin
          if (hit_cnt_q != CountMax) begin
            hit_cnt_d = hit_cnt_q + 1'b1;
            total_d   = total_q + 1'b1;
          end
        end
        vdc_pkg::CLASS_COLD: begin
          if (cold_cnt_q != CountMax) begin
            cold_cnt_d = cold_cnt_q + 1'b1;
            total_d    = total_q + 1'b1;
          end
        end
        vdc_pkg::CLASS_COLLISION: begin
          if (coll_cnt_q != CountMax) begin
            coll_cnt_d = coll_cnt_q + 1'b1;
            total_d    = total_q + 1'b1;
          end
        end
        vdc_pkg::CLASS_REWRITTEN: begin
          if (rewr_cnt_q != CountMax) begin
            rewr_cnt_d = rewr_cnt_q + 1'b1;
            total_d    = total_q + 1'b1;
          end
        end
        default: begin
          // bypassed: nothing counted
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q  <= '0;
      cold_cnt_q <= '0;
      coll_cnt_q <= '0;
      rewr_cnt_q <= '0;
      total_q    <= '0;
    end else begin
      hit_cnt_q  <= hit_cnt_d;
      cold_cnt_q <= cold_cnt_d;
      coll_cnt_q <= coll_cnt_d;
      rewr_cnt_q <= rewr_cnt_d;
      total_q    <= total_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                  done_q;
  logic                  ok_q;
  logic                  fc_q;
  logic [2:0]            cls_q;
  logic [INSN_WIDTH-1:0] word_q;
  logic [7:0]            len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls;
    fc_q  <= is_hit;
    if (is_hit) begin
      ok_q   <= 1'b1;
      word_q <= rd_insn_q;
      len_q  <= rd_len_q;
    end else if (s3_item_q.dec_ok) begin
      ok_q   <= 1'b1;
      word_q <= s3_word_q;
      len_q  <= s3_item_q.dec_len;
    end else begin
      ok_q   <= 1'b0;
      word_q <= '0;
      len_q  <= '0;
    end
  end

  // counters already hold the values after the lookup being shown
  assign done_o            = done_q;
  assign result_ok_o       = ok_q;
  assign from_cache_o      = fc_q;
  assign lookup_class_o    = cls_q;
  assign insn_word_o       = word_q;
  assign insn_length_o     = len_q;
  assign hit_total_o       = hit_cnt_q;
  assign cold_total_o      = cold_cnt_q;
  assign collision_total_o = coll_cnt_q;
  assign rewritten_total_o = rewr_cnt_q;
  assign lookup_total_o    = total_q;

endmodule

`default_nettype wire
